/* src/ldx_pkg.sv */
// Shared types and constants for the log record deframer.
`default_nettype none
package ldx_pkg;

  localparam int unsigned OFF_W = 16;
  localparam int unsigned ID_W  = 16;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  // Record layout offsets
  localparam logic [OFF_W-1:0] OFF_SYNC    = 16'd0;
  localparam logic [OFF_W-1:0] OFF_LEN_LO  = 16'd1;
  localparam logic [OFF_W-1:0] OFF_LEN_HI  = 16'd2;
  localparam logic [OFF_W-1:0] OFF_CSUM    = 16'd3;
  localparam logic [OFF_W-1:0] OFF_ID_LO   = 16'd4;
  localparam logic [OFF_W-1:0] OFF_ID_HI   = 16'd5;
  localparam logic [OFF_W-1:0] OFF_KEY     = 16'd6;
  localparam logic [OFF_W-1:0] OFF_PAYLOAD = 16'd10;
  localparam logic [OFF_W-1:0] MIN_LEN     = 16'd12;
  localparam int unsigned      TRAILER_LEN = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK_ID = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ATTITUDE_ID = 8'd1;

  typedef enum logic [1:0] {
    KIND_FEEDBACK = 2'd0,
    KIND_ATTITUDE = 2'd1,
    KIND_UNKNOWN  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_TRUNC  = 2'd2
  } err_t;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             byte_valid;
    kind_t            record_kind;
    logic [ID_W-1:0]  record_id;
    logic             record_last;
    err_t             frame_error;
    logic [CNT_W-1:0] buffer_number;
  } res_t;

endpackage
`default_nettype wire

/* src/ldx_if.sv */
// Handshake channel interfaces: input bytes, result items and configuration writes.
`default_nettype none
interface ldx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface ldx_out_if import ldx_pkg::*;;
  logic             valid;
  logic             ready;
  logic [7:0]       payload_byte;
  logic             byte_valid;
  logic [1:0]       record_kind;
  logic [ID_W-1:0]  record_id;
  logic             record_last;
  logic [1:0]       frame_error;
  logic [CNT_W-1:0] buffer_number;

  modport source (output valid, output payload_byte, output byte_valid, output record_kind,
                  output record_id, output record_last, output frame_error,
                  output buffer_number, input ready);
  modport sink   (input valid, input payload_byte, input byte_valid, input record_kind,
                  input record_id, input record_last, input frame_error,
                  input buffer_number, output ready);
endinterface

interface ldx_cfg_if import ldx_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/log_record_deframer_xor_unit.sv */
// Log record deframer: splits buffer bytes into records and emits XOR-decoded payload.
//
// Usage:
//   in_ch  carries one raw buffer byte per transfer; buffer_end marks the
//          final byte of a buffer.
//   out_ch carries at most one result per input byte: a decoded payload byte
//          tagged with record kind, id, last mark and buffer number, or an
//          error report (length below minimum, record truncated by buffer end).
//   cfg_ch writes the feedback and attitude id registers; always ready.
// Results are registered in the output register, or in the skid register while
// out_ch stalls. Throughput: one byte per cycle while in_ch.ready is high; framing
// state advances on each input transfer through a single compare/capture/XOR step
// into the result register. Stall: a two-entry result buffer (output register plus
// skid register) lets the block hold one more result while a result waits;
// in_ch.ready drops only while the skid register is full.
// Reset: rst_n low clears framing state, buffer count, id registers and the
// result buffer; no result is pending afterward.
`default_nettype none
module log_record_deframer_xor_unit import ldx_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ldx_in_if.sink    in_ch,
  ldx_out_if.source out_ch,
  ldx_cfg_if.sink   cfg_ch
);

  logic [ID_W-1:0]  feedback_id_r, attitude_id_r;
  logic [OFF_W-1:0] byte_offset_r, byte_offset_nxt;
  logic [OFF_W-1:0] record_length_r, record_length_nxt;
  logic [ID_W-1:0]  current_id_r, current_id_nxt;
  logic [7:0]       xor_key_r, xor_key_nxt;
  logic             skip_r, skip_nxt;
  logic             in_buffer_r, in_buffer_nxt;
  logic [CNT_W-1:0] buffer_count_r, buffer_count_nxt;

  res_t             out_r, skid_r, res;
  logic             out_valid_r, skid_valid_r;
  logic             emit;
  logic             in_xfer;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !skid_valid_r;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feedback_id_r <= '0;
      attitude_id_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_FEEDBACK_ID: feedback_id_r <= cfg_ch.data[ID_W-1:0];
        CFG_ATTITUDE_ID: attitude_id_r <= cfg_ch.data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Framing step for one byte
  always_comb begin
    logic [7:0]       b;
    logic [OFF_W-1:0] off;
    logic [OFF_W:0]   off_x, len_x;
    logic             len_err, data, term, trunc, id_known;

    b   = in_ch.data_byte;
    off = byte_offset_r;

    record_length_nxt = record_length_r;
    current_id_nxt    = current_id_r;
    xor_key_nxt       = xor_key_r;
    skip_nxt          = skip_r;
    byte_offset_nxt   = byte_offset_r;
    in_buffer_nxt     = 1'b1;
    buffer_count_nxt  = in_buffer_r ? buffer_count_r : buffer_count_r + 1'b1;

    case (off)
      OFF_SYNC: begin
        record_length_nxt = '0;
        current_id_nxt    = '0;
        xor_key_nxt       = '0;
      end
      OFF_LEN_LO: record_length_nxt = {8'd0, b};
      OFF_LEN_HI: record_length_nxt = {b, record_length_r[7:0]};
      OFF_ID_LO:  current_id_nxt    = {8'd0, b};
      OFF_ID_HI:  current_id_nxt    = {b, current_id_r[7:0]};
      OFF_KEY:    xor_key_nxt       = b;
      default: ;
    endcase

    off_x = {1'b0, off};
    len_x = {1'b0, record_length_nxt};

    len_err  = (off == OFF_LEN_HI) && (record_length_nxt < MIN_LEN);
    data     = !len_err && (off >= OFF_PAYLOAD)
               && (off_x + (OFF_W+1)'(TRAILER_LEN) < len_x);
    term     = (off >= OFF_CSUM) && (off_x + 17'd1 == len_x);
    trunc    = !len_err && in_ch.buffer_end && (off >= OFF_LEN_HI) && !term;
    id_known = !len_err && (off >= OFF_ID_HI);

    res.payload_byte  = data ? (b ^ xor_key_r) : 8'd0;
    res.byte_valid    = data;
    res.record_last   = data && ((off_x + (OFF_W+1)'(TRAILER_LEN + 1) == len_x) || trunc);
    res.frame_error   = len_err ? ERR_LENGTH : (trunc ? ERR_TRUNC : ERR_NONE);
    res.record_id     = id_known ? current_id_nxt : '0;
    res.buffer_number = buffer_count_nxt;
    if (!id_known)
      res.record_kind = KIND_UNKNOWN;
    else if (current_id_nxt == feedback_id_r)
      res.record_kind = KIND_FEEDBACK;
    else if (current_id_nxt == attitude_id_r)
      res.record_kind = KIND_ATTITUDE;
    else
      res.record_kind = KIND_UNKNOWN;

    emit = !skip_r && (len_err || data || trunc);

    if (skip_r) begin
      // hold capture state while skipping to buffer end
      record_length_nxt = record_length_r;
      current_id_nxt    = current_id_r;
      xor_key_nxt       = xor_key_r;
    end else if (len_err) begin
      skip_nxt = 1'b1;
    end else begin
      byte_offset_nxt = term ? '0 : off + 1'b1;
    end

    if (in_ch.buffer_end) begin
      byte_offset_nxt = '0;
      skip_nxt        = 1'b0;
      in_buffer_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r   <= '0;
      record_length_r <= '0;
      current_id_r    <= '0;
      xor_key_r       <= '0;
      skip_r          <= 1'b0;
      in_buffer_r     <= 1'b0;
      buffer_count_r  <= '0;
    end else if (in_xfer) begin
      byte_offset_r   <= byte_offset_nxt;
      record_length_r <= record_length_nxt;
      current_id_r    <= current_id_nxt;
      xor_key_r       <= xor_key_nxt;
      skip_r          <= skip_nxt;
      in_buffer_r     <= in_buffer_nxt;
      buffer_count_r  <= buffer_count_nxt;
    end
  end

  // Result buffer: output register with a skid register behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_xfer && emit;
      end
    end else if (in_xfer && emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_xfer && emit) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.payload_byte  = out_r.payload_byte;
  assign out_ch.byte_valid    = out_r.byte_valid;
  assign out_ch.record_kind   = out_r.record_kind;
  assign out_ch.record_id     = out_r.record_id;
  assign out_ch.record_last   = out_r.record_last;
  assign out_ch.frame_error   = out_r.frame_error;
  assign out_ch.buffer_number = out_r.buffer_number;

endmodule
`default_nettype wire

/* tb/sv/ldx_record_checker.sv */
// Deframer checker: predicts each result from input and id register transfers and compares.
module ldx_record_checker import ldx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ldx_in_if    in_mon,
  ldx_out_if   out_mon,
  ldx_cfg_if   cfg_mon,
  output int   fail_count,
  output int   results_due,
  output int   inputs_seen,
  output int   results_seen,
  output int   payload_seen,
  output int   length_errors_seen,
  output int   truncations_seen
);

  // Predictor copy of the registers and framing state
  logic [ID_W-1:0]  feedback_id_reg;
  logic [ID_W-1:0]  attitude_id_reg;
  logic [OFF_W-1:0] rec_off;
  logic [OFF_W-1:0] rec_len;
  logic [ID_W-1:0]  rec_id;
  logic [7:0]       rec_key;
  bit               skipping;
  logic [15:0]      buf_pos;
  logic [CNT_W-1:0] buf_count;

  res_t expected_results[$];

  // Advance the framing state by one byte; return 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, input bit final_byte,
                                      output res_t r);
    int unsigned off;
    int unsigned len;
    bit id_known;
    bit emit;
    bit data;
    bit last;
    err_t err;
    logic [7:0] pay;
    emit = 1'b0;
    data = 1'b0;
    last = 1'b0;
    err  = ERR_NONE;
    pay  = '0;
    if (buf_pos == '0) buf_count = buf_count + 1'b1;
    if (buf_pos != 16'hFFFF) buf_pos = buf_pos + 1'b1;
    off = rec_off;
    id_known = (off >= OFF_ID_HI);
    if (!skipping) begin
      case (rec_off)
        OFF_SYNC: begin
          rec_len = '0;
          rec_id  = '0;
          rec_key = '0;
        end
        OFF_LEN_LO: rec_len = {8'h00, b};
        OFF_LEN_HI: rec_len = rec_len | {b, 8'h00};
        OFF_ID_LO:  rec_id  = {8'h00, b};
        OFF_ID_HI:  rec_id  = rec_id | {b, 8'h00};
        OFF_KEY:    rec_key = b;
        default: ;
      endcase
      len = rec_len;
      if (off == OFF_LEN_HI && len < MIN_LEN) begin
        // short length: report once, then ignore the rest of the buffer
        emit = 1'b1;
        err = ERR_LENGTH;
        id_known = 1'b0;
        skipping = 1'b1;
      end else begin
        if (off >= OFF_PAYLOAD && off + TRAILER_LEN < len) begin
          emit = 1'b1;
          data = 1'b1;
          pay  = b ^ rec_key;
          last = (off + TRAILER_LEN + 1 == len);
        end
        if (final_byte && off >= OFF_LEN_HI && !(off >= OFF_CSUM && off + 1 == len)) begin
          emit = 1'b1;
          err = ERR_TRUNC;
          if (data) last = 1'b1;
        end
        if (off >= OFF_CSUM && off + 1 == len) rec_off = '0;
        else rec_off = rec_off + 1'b1;
      end
    end
    if (final_byte) begin
      rec_off  = '0;
      skipping = 1'b0;
      buf_pos  = '0;
    end
    r.payload_byte  = pay;
    r.byte_valid    = data;
    r.record_last   = last;
    r.frame_error   = err;
    r.buffer_number = buf_count;
    r.record_kind   = KIND_UNKNOWN;
    r.record_id     = '0;
    if (id_known) begin
      r.record_id = rec_id;
      if (rec_id == feedback_id_reg) r.record_kind = KIND_FEEDBACK;
      else if (rec_id == attitude_id_reg) r.record_kind = KIND_ATTITUDE;
    end
    return emit;
  endfunction

  function automatic bit field_ok(input string name, input longint unsigned want,
                                  input longint unsigned got);
    if (want == got) return 1'b1;
    $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    res_t predicted;
    int bad;
    bad = 0;
    if (!rst_n) begin
      feedback_id_reg = '0;
      attitude_id_reg = '0;
      rec_off   = '0;
      rec_len   = '0;
      rec_id    = '0;
      rec_key   = '0;
      skipping  = 1'b0;
      buf_pos   = '0;
      buf_count = '0;
      expected_results.delete();
      results_due <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_FEEDBACK_ID: feedback_id_reg = cfg_mon.data;
          CFG_ATTITUDE_ID: attitude_id_reg = cfg_mon.data;
          default: ;
        endcase
      end
      // Compare before predicting: a result never leaves on the edge of its own input.
      if (out_mon.valid && out_mon.ready) begin
        got.payload_byte  = out_mon.payload_byte;
        got.byte_valid    = out_mon.byte_valid;
        got.record_kind   = kind_t'(out_mon.record_kind);
        got.record_id     = out_mon.record_id;
        got.record_last   = out_mon.record_last;
        got.frame_error   = err_t'(out_mon.frame_error);
        got.buffer_number = out_mon.buffer_number;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
          bad++;
        end else begin
          want = expected_results.pop_front();
          bad += !field_ok("payload_byte", want.payload_byte, got.payload_byte);
          bad += !field_ok("byte_valid", want.byte_valid, got.byte_valid);
          bad += !field_ok("record_kind", want.record_kind, got.record_kind);
          bad += !field_ok("record_id", want.record_id, got.record_id);
          bad += !field_ok("record_last", want.record_last, got.record_last);
          bad += !field_ok("frame_error", want.frame_error, got.frame_error);
          bad += !field_ok("buffer_number", want.buffer_number, got.buffer_number);
        end
        results_seen       <= results_seen + 1;
        payload_seen       <= payload_seen + (got.byte_valid ? 1 : 0);
        length_errors_seen <= length_errors_seen + (got.frame_error == ERR_LENGTH ? 1 : 0);
        truncations_seen   <= truncations_seen + (got.frame_error == ERR_TRUNC ? 1 : 0);
      end
      if (in_mon.valid && in_mon.ready) begin
        if (deframe_byte(in_mon.data_byte, in_mon.buffer_end, predicted))
          expected_results.insert(expected_results.size(), predicted);
        inputs_seen <= inputs_seen + 1;
      end
      results_due <= expected_results.size();
      fail_count  <= fail_count + bad;
    end
  end

endmodule

/* tb/sv/tb_log_record_deframer_xor_unit.sv */
// Testbench top: feeds log buffers and id writes to the deframer and reports the verdict.
module tb_log_record_deframer_xor_unit import ldx_pkg::*;;

  localparam int LIMIT_CYCLES = 100000;
  localparam int LONG_HOLD    = 60;

  logic clk;
  logic rst_n;

  ldx_in_if  in_ch();
  ldx_out_if out_ch();
  ldx_cfg_if cfg_ch();

  int fail_count;
  int results_due;
  int inputs_seen;
  int results_seen;
  int payload_seen;
  int length_errors_seen;
  int truncations_seen;

  int cycles = 0;
  int bytes_counted = 0;
  int buffers_sent = 0;
  bit idle_on = 1'b1;
  bit calm_tail = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int stall_left = 0;
  logic [ID_W-1:0] feedback_id;
  logic [ID_W-1:0] attitude_id;

  log_record_deframer_xor_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ldx_record_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mon             (in_ch),
    .out_mon            (out_ch),
    .cfg_mon            (cfg_ch),
    .fail_count         (fail_count),
    .results_due        (results_due),
    .inputs_seen        (inputs_seen),
    .results_seen       (results_seen),
    .payload_seen       (payload_seen),
    .length_errors_seen (length_errors_seen),
    .truncations_seen   (truncations_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold that backs up the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_req && !hold_done) begin
      out_ch.ready <= 1'b0;
      stall_left <= LONG_HOLD - 1;
      hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic put_byte(input logic [7:0] b, input bit last_of_buffer, input bit acted);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.buffer_end <= last_of_buffer;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (acted) bytes_counted++;
    if (last_of_buffer) buffers_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 3))
      0: return feedback_id;
      1: return attitude_id;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send offsets 0..stop-1 of one record; fill < 0 means random filler bytes.
  task automatic put_record(input logic [OFF_W-1:0] len, input logic [ID_W-1:0] id,
                            input logic [7:0] key, input int stop, input bit closes,
                            input int fill);
    logic [7:0] b;
    for (int off = 0; off < stop; off++) begin
      case (off)
        OFF_LEN_LO: b = len[7:0];
        OFF_LEN_HI: b = len[15:8];
        OFF_ID_LO:  b = id[7:0];
        OFF_ID_HI:  b = id[15:8];
        OFF_KEY:    b = key;
        default:    b = (fill < 0) ? pick_byte() : fill[7:0];
      endcase
      // bytes after a short length are skipped by the block
      put_byte(b, closes && off == stop - 1, !(len < MIN_LEN && off > OFF_LEN_HI));
    end
  endtask

  task automatic random_buffer();
    int n;
    int len;
    int stop;
    bit closing;
    if (!calm_tail) idle_on <= ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) put_byte(8'($urandom), i == n - 1, 1'b1);
      return;
    end
    n = $urandom_range(1, 3);
    for (int r = 0; r < n; r++) begin
      closing = (r == n - 1);
      case ($urandom_range(0, 19))
        0: begin
          put_record(16'($urandom_range(0, MIN_LEN - 1)), pick_id(), 8'($urandom),
                     $urandom_range(3, 8), 1'b1, -1);
          return;
        end
        1: begin
          // length far beyond the buffer: cut short
          put_record(16'($urandom_range(256, 65535)), pick_id(), 8'($urandom),
                     $urandom_range(3, 30), 1'b1, -1);
          return;
        end
        default: begin
          len = $urandom_range(MIN_LEN, 28);
          stop = len;
          if (closing && $urandom_range(0, 4) == 0) stop = $urandom_range(1, len - 1);
          put_record(16'(len), pick_id(), 8'($urandom), stop, closing, -1);
        end
      endcase
    end
  endtask

  task automatic random_until(input int target);
    while (bytes_counted < target) random_buffer();
  endtask

  // Hold input until every expected result has left, then allow the output stage to drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_ids(input logic [ID_W-1:0] fb, input logic [ID_W-1:0] att);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_FEEDBACK_ID;
    cfg_ch.data  <= fb;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= CFG_ATTITUDE_ID;
    cfg_ch.data  <= att;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    feedback_id = fb;
    attitude_id = att;
  endtask

  initial begin : stimulus
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.buffer_end = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_FEEDBACK_ID;
    cfg_ch.data      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_ids(16'hFFFF, 16'h0000);
    // minimal record with one payload byte, then a record opening on the final byte
    put_record(13, 16'hFFFF, 8'hFF, 13, 1'b0, 8'h00);
    put_record(20, 16'h0000, 8'h00, 1, 1'b1, 8'hFF);
    // short length
    put_record(5, 16'h0000, 8'h00, 4, 1'b1, 8'hFF);
    // maximum length cut before the id is known
    put_record(16'hFFFF, 16'h0000, 8'h5A, 4, 1'b1, 8'h00);
    // record opening one byte before the end
    put_record(13, 16'h0000, 8'h00, 2, 1'b1, 8'hFF);
    // buffer ends on the length high byte
    put_record(MIN_LEN, 16'h0000, 8'h00, 3, 1'b1, 8'h00);
    settle();

    set_ids(16'h1234, 16'h1234);
    hold_req <= 1'b1;
    put_record(40, 16'h1234, 8'($urandom), 40, 1'b1, -1);
    random_until(200);
    settle();

    set_ids(16'h0000, 16'hFFFF);
    random_until(400);
    settle();

    set_ids(16'($urandom), 16'($urandom));
    random_until(520);
    calm_tail = 1'b1;
    idle_on <= 1'b0;
    random_until(630);
    settle();

    $display("Covered %0d input bytes in %0d buffers under four id settings.",
             inputs_seen, buffers_sent);
    $display("Saw %0d results: %0d payload bytes, %0d length errors, %0d truncations.",
             results_seen, payload_seen, length_errors_seen, truncations_seen);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
